// File: sv/sal_pkg.sv
// Shared types and constants for the sign announcement lifecycle block.
// No dependencies; imported by every module of the block.
package sal_pkg;

	// Episode state codes
	typedef enum logic [1:0] {
		MODE_ARMED     = 2'd0,
		MODE_CONFIRMED = 2'd1,
		MODE_RELEASING = 2'd2
	} mode_t;

	// Configuration register map (word index taken from paddr[2])
	localparam int unsigned PaddrWidth   = 3;
	localparam logic        RegRearmIdx  = 1'b0;
	localparam logic [15:0] RearmResetMs = 16'd2000;
	localparam logic [15:0] RepeatMax    = 16'hFFFF;

	// One input frame
	typedef struct packed {
		logic [7:0]  seen_class;
		logic        detect_suppressed;
		logic        vote_confirmed;
		logic [7:0]  vote_class;
		logic [31:0] now_ms;
	} frame_t;

	// One result item
	typedef struct packed {
		logic        fired;
		logic [7:0]  announced_class;
		mode_t       episode_mode;
		logic [15:0] repeat_count;
	} result_t;

endpackage

// File: sv/sal_cfg.sv
// APB-style configuration register holding the re-arm absence time.
// Depends on sal_pkg for the register map and reset value.
module sal_cfg import sal_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [15:0]           rearm_after_ms
);

	logic        wr_en;
	logic        sel_rearm;
	logic [15:0] rearm_q;

	assign pready    = 1'b1;
	assign sel_rearm = (paddr[PaddrWidth-1] == RegRearmIdx);
	assign wr_en     = psel & penable & pwrite & pready & sel_rearm;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm_q <= RearmResetMs;
		end else if (wr_en) begin
			rearm_q <= pwdata[15:0];
		end
	end

	// readback
	always_comb begin
		prdata = '0;
		if (sel_rearm) begin
			prdata = {16'd0, rearm_q};
		end
	end

	assign rearm_after_ms = rearm_q;

endmodule

// File: sv/sal_step.sv
// Episode state registers and the per-frame update logic.
// Depends on sal_pkg for frame, result and mode types.
module sal_step import sal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  frame_t      frame,
	input  logic [15:0] rearm_after_ms,
	output result_t     result
);

	mode_t       mode_q, mode_d;
	logic [7:0]  class_q, class_d;
	logic [31:0] last_seen_q, last_seen_d;
	logic [15:0] repeat_q, repeat_d;

	logic [7:0]  candidate;
	logic [31:0] elapsed;
	logic        in_episode;

	assign candidate  = frame.detect_suppressed ? 8'd0 : frame.seen_class;
	assign elapsed    = frame.now_ms - last_seen_q;
	assign in_episode = (mode_q == MODE_CONFIRMED) || (mode_q == MODE_RELEASING);

	// next state and result for the frame in the input register
	always_comb begin
		mode_d                 = mode_q;
		class_d                = class_q;
		last_seen_d            = last_seen_q;
		repeat_d               = repeat_q;
		result.fired           = 1'b0;
		result.announced_class = 8'd0;
		if (frame.vote_confirmed && frame.vote_class != 8'd0) begin
			if (mode_q != MODE_CONFIRMED || frame.vote_class != class_q) begin
				// new episode or changed value: announce
				mode_d                 = MODE_CONFIRMED;
				class_d                = frame.vote_class;
				last_seen_d            = frame.now_ms;
				repeat_d               = 16'd0;
				result.fired           = 1'b1;
				result.announced_class = frame.vote_class;
			end else begin
				// repeat confirmation: count, saturating
				last_seen_d = frame.now_ms;
				if (repeat_q != RepeatMax) begin
					repeat_d = repeat_q + 16'd1;
				end
			end
		end else if (in_episode) begin
			if (candidate != 8'd0 && candidate == class_q) begin
				last_seen_d = frame.now_ms;
				mode_d      = MODE_CONFIRMED;
			end else if (candidate == 8'd0) begin
				if (mode_q == MODE_CONFIRMED) begin
					mode_d = MODE_RELEASING;
				end
				if (elapsed >= {16'd0, rearm_after_ms}) begin
					mode_d      = MODE_ARMED;
					class_d     = 8'd0;
					last_seen_d = 32'd0;
					repeat_d    = 16'd0;
				end
			end
		end
		result.episode_mode = mode_d;
		result.repeat_count = repeat_d;
	end

	// state registers, updated once per processed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ARMED;
			class_q     <= 8'd0;
			last_seen_q <= 32'd0;
			repeat_q    <= 16'd0;
		end else if (advance) begin
			mode_q      <= mode_d;
			class_q     <= class_d;
			last_seen_q <= last_seen_d;
			repeat_q    <= repeat_d;
		end
	end

endmodule

// File: sv/sign_announce_lifecycle.sv
// Top level of the speed-sign announcement lifecycle block.
// Depends on sal_pkg, sal_cfg and sal_step.
//
// Each accepted frame yields exactly one result. A frame is captured in an
// input register, the episode update is combinational, and the result lands
// in an output register; one frame per cycle is sustained while out_ready is
// high. The input side keeps accepting while a result waits, as long as the
// input register can move. rearm_after_ms sits at byte address 0; the user
// must write it only while idle, since the block itself does not enforce it.
module sign_announce_lifecycle import sal_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PaddrWidth-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// input frames
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            seen_class,
	input  logic                  detect_suppressed,
	input  logic                  vote_confirmed,
	input  logic [7:0]            vote_class,
	input  logic [31:0]           now_ms,
	// results
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  fired,
	output logic [7:0]            announced_class,
	output logic [1:0]            episode_mode,
	output logic [15:0]           repeat_count
);

	logic        valid_s1;
	frame_t      frame_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result_d;
	logic        advance;
	logic [15:0] rearm_after_ms;

	// stage 1 moves into the output register when that register frees up
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	sal_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.rearm_after_ms (rearm_after_ms)
	);

	sal_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.frame          (frame_s1),
		.rearm_after_ms (rearm_after_ms),
		.result         (result_d)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1.seen_class        <= seen_class;
			frame_s1.detect_suppressed <= detect_suppressed;
			frame_s1.vote_confirmed    <= vote_confirmed;
			frame_s1.vote_class        <= vote_class;
			frame_s1.now_ms            <= now_ms;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid       = valid_s2;
	assign fired           = result_s2.fired;
	assign announced_class = result_s2.announced_class;
	assign episode_mode    = result_s2.episode_mode;
	assign repeat_count    = result_s2.repeat_count;

endmodule

// File: tb/tb_sign_announce_lifecycle.sv
// Self-checking bench for sign_announce_lifecycle: random and directed frames,
// an in-bench episode predictor, and APB writes of rearm_after_ms.
// Depends on sal_pkg and the sign_announce_lifecycle RTL.
`timescale 1ns / 100ps

module tb_sign_announce_lifecycle;
	import sal_pkg::*;

	localparam int unsigned WatchdogLimit = 5000;
	localparam int unsigned HoldOffCycles = 80;
	localparam int unsigned DrainCycles   = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PaddrWidth-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            seen_class = '0;
	logic                  detect_suppressed = 1'b0;
	logic                  vote_confirmed = 1'b0;
	logic [7:0]            vote_class = '0;
	logic [31:0]           now_ms = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  fired;
	logic [7:0]            announced_class;
	logic [1:0]            episode_mode;
	logic [15:0]           repeat_count;

	sign_announce_lifecycle DUT (.*);

	// Predicted episode state and its configuration copy
	mode_t       ep_mode = MODE_ARMED;
	logic [7:0]  ep_class = '0;
	logic [31:0] ep_seen_ms = '0;
	logic [15:0] ep_repeats = '0;
	logic [15:0] rearm_ms = RearmResetMs;

	frame_t      pending_frames[$];
	result_t     sign_results[$];
	int unsigned frames_pushed = 0;
	int unsigned frames_accepted = 0;
	int unsigned error_count = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_cycles_left = 0;
	bit          hold_request = 1'b0;
	bit          no_idle = 1'b0;
	bit          in_fire = 1'b0;
	frame_t      next_frame;
	result_t     want;

	initial begin
		forever #5 clk = ~clk;
	end

	// Episode update for one frame; returns the result it should produce
	function automatic result_t advance_episode(frame_t f);
		result_t     r;
		logic [7:0]  candidate;
		logic [31:0] elapsed;
		r = '0;
		candidate = f.detect_suppressed ? 8'd0 : f.seen_class;
		if (f.vote_confirmed && f.vote_class != 8'd0) begin
			if (ep_mode != MODE_CONFIRMED || f.vote_class != ep_class) begin
				// new episode, or value changed: announce
				ep_mode = MODE_CONFIRMED;
				ep_class = f.vote_class;
				ep_seen_ms = f.now_ms;
				ep_repeats = '0;
				r.fired = 1'b1;
				r.announced_class = f.vote_class;
			end else begin
				ep_seen_ms = f.now_ms;
				if (ep_repeats != RepeatMax)
					ep_repeats = ep_repeats + 16'd1;
			end
		end else if (ep_mode != MODE_ARMED) begin
			if (candidate != 8'd0 && candidate == ep_class) begin
				ep_seen_ms = f.now_ms;
				ep_mode = MODE_CONFIRMED;
			end else if (candidate == 8'd0) begin
				if (ep_mode == MODE_CONFIRMED)
					ep_mode = MODE_RELEASING;
				elapsed = f.now_ms - ep_seen_ms;
				if (elapsed >= {16'd0, rearm_ms}) begin
					ep_mode = MODE_ARMED;
					ep_class = '0;
					ep_seen_ms = '0;
					ep_repeats = '0;
				end
			end
		end
		r.episode_mode = ep_mode;
		r.repeat_count = ep_repeats;
		return r;
	endfunction

	function automatic frame_t make_frame(logic [7:0] seen, logic supp, logic conf,
			logic [7:0] vote, logic [31:0] t);
		return {seen, supp, conf, vote, t};
	endfunction

	task automatic push_frame(frame_t f);
		pending_frames.push_back(f);
		frames_pushed++;
	endtask

	task automatic compare_field(string field, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
				act_val);
			error_count++;
		end
	endtask

	// Episodes of confirms, presence and absence around one class, with noise
	task automatic queue_random_frames(int count);
		frame_t      f;
		logic [7:0]  cls;
		logic [31:0] t;
		logic [31:0] anchor;
		int unsigned span;
		int unsigned kind;
		int unsigned pick;
		cls = 8'($urandom_range(1, 255));
		t = $urandom;
		anchor = t;
		span = rearm_ms + 1;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			pick = $urandom_range(9);
			// mostly short steps, some right at the re-arm edge, some long gaps
			if (pick < 6)
				t = t + $urandom_range(0, span / 3);
			else if (pick < 8)
				t = anchor + rearm_ms - $urandom_range(0, 1);
			else
				t = t + $urandom_range(span, 2 * span);
			f = make_frame(8'($urandom), ($urandom_range(9) == 0), 1'b0, 8'($urandom), t);
			if (kind < 8) begin
				f = make_frame(8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
					$urandom);
			end else if (kind < 35) begin
				if ($urandom_range(9) == 0)
					cls = 8'($urandom_range(1, 255));
				f.vote_confirmed = 1'b1;
				f.vote_class = ($urandom_range(19) == 0) ? 8'd0 : cls;
				if (f.vote_class != 8'd0)
					anchor = t;
			end else if (kind < 60) begin
				f.seen_class = cls;
				if (!f.detect_suppressed)
					anchor = t;
			end else if (kind < 85) begin
				if ($urandom_range(1))
					f.seen_class = 8'd0;
				else
					f.detect_suppressed = 1'b1;
			end
			push_frame(f);
		end
	endtask

	// Same class confirmed over and over, counted as repeats
	task automatic queue_repeat_run(int count);
		logic [7:0]  cls;
		logic [31:0] t;
		cls = 8'($urandom_range(1, 255));
		t = $urandom;
		for (int i = 0; i < count; i++) begin
			t = t + $urandom_range(0, 100);
			push_frame(make_frame(8'($urandom), 1'($urandom), 1'b1, cls, t));
		end
	endtask

	task automatic wait_drained();
		while (frames_accepted != frames_pushed || sign_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_rearm(logic [15:0] ms);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {RegRearmIdx, 2'b00};
		pwdata <= {16'd0, ms};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rearm_ms = ms;
	endtask

	// Frame driver: next transfer offered once the previous one is taken
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending_frames.size() != 0 && (no_idle || $urandom_range(99) >= 15)) begin
				next_frame = pending_frames.pop_front();
				in_valid <= 1'b1;
				{seen_class, detect_suppressed, vote_confirmed, vote_class, now_ms} <=
					next_frame;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_cycles_left != 0) begin
			out_ready <= 1'b0;
			hold_cycles_left = hold_cycles_left - 1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_cycles_left = HoldOffCycles;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 15);
		end
	end

	// Monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				sign_results.push_back(advance_episode(frame_t'({seen_class,
					detect_suppressed, vote_confirmed, vote_class, now_ms})));
				frames_accepted++;
			end
			if (out_valid && out_ready) begin
				if (sign_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
						$time, fired, announced_class, episode_mode, repeat_count);
					error_count++;
				end else begin
					want = sign_results.pop_front();
					compare_field("fired", want.fired, fired);
					compare_field("announced_class", want.announced_class, announced_class);
					compare_field("episode_mode", want.episode_mode, episode_mode);
					compare_field("repeat_count", want.repeat_count, repeat_count);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset re-arm time of 2000 ms
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'd1000));    // absent while armed
		push_frame(make_frame(8'd0, 1'b0, 1'b1, 8'd0, 32'd1000));    // confirm of class 0
		push_frame(make_frame(8'd0, 1'b0, 1'b1, 8'hFF, 32'd1000));   // fires
		push_frame(make_frame(8'd0, 1'b0, 1'b1, 8'hFF, 32'd1100));   // repeat, counted
		push_frame(make_frame(8'h12, 1'b0, 1'b0, 8'd0, 32'd1200));   // other sign
		push_frame(make_frame(8'hFF, 1'b1, 1'b0, 8'd0, 32'd1300));   // suppressed: releasing
		push_frame(make_frame(8'hFF, 1'b0, 1'b0, 8'd0, 32'd1400));   // seen again
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'd1500));    // releasing
		push_frame(make_frame(8'd0, 1'b0, 1'b1, 8'hFF, 32'd1600));   // same class re-fires
		push_frame(make_frame(8'd0, 1'b0, 1'b1, 8'h01, 32'd1700));   // class change fires
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'd3699));    // one ms short
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'd3700));    // exactly at limit
		push_frame(make_frame(8'h80, 1'b0, 1'b1, 8'h80, 32'hFFFF_FF00));
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'h0000_0100)); // across the wrap
		push_frame(make_frame(8'd0, 1'b0, 1'b0, 8'd0, 32'h0000_06D0)); // wrap, re-arms
		push_frame(make_frame(8'h33, 1'b0, 1'b1, 8'd0, 32'd5000));   // sign while armed
		push_frame(make_frame(8'h55, 1'b1, 1'b1, 8'hAA, 32'hFFFF_FFFF));
		push_frame(make_frame(8'h55, 1'b1, 1'b1, 8'hAA, 32'hFFFF_FFFF));
		push_frame(make_frame(8'hAA, 1'b0, 1'b1, 8'd0, 32'd10));     // presence via seen
		queue_random_frames(120);
		wait_drained();

		// Zero re-arm time: first absent frame re-arms
		write_rearm(16'd0);
		queue_random_frames(60);
		wait_drained();

		// Longest re-arm time, with the receiver held off so the input backs up
		write_rearm(16'hFFFF);
		queue_random_frames(80);
		hold_request = 1'b1;
		wait_drained();

		// Random setting, back-to-back traffic on both sides
		write_rearm(16'($urandom_range(1, 65534)));
		no_idle = 1'b1;
		queue_random_frames(100);
		wait_drained();
		no_idle = 1'b0;

		write_rearm(16'd1);
		queue_random_frames(60);
		wait_drained();

		// Long run of repeat confirmations
		write_rearm(RearmResetMs);
		queue_repeat_run(100);
		wait_drained();

		repeat (DrainCycles) @(negedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
